/* rtl/core/slcg_pkg.sv */
package slcg_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SEED_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(SEED_STEPS);

    localparam int VAL_W = 31;
    localparam int MUL_C_W = 15;
    localparam int MUL_W = VAL_W + MUL_C_W;

    localparam logic [MUL_C_W-1:0] LCG_MUL = 15'd16807;
    localparam logic [VAL_W-1:0]   LCG_MOD = 31'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]   SHUF_DIV = 31'(1 + (2147483646 / TABLE_DEPTH));

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_FOLD,
        S_DRAW_MUL,
        S_DRAW_FOLD
    } t_state;

    // negative seeds are negated, everything else (and -2^31) starts at 1
    function automatic logic [VAL_W-1:0] seed_start(input logic [31:0] raw);
        logic [31:0] neg;
        neg = 32'd0 - raw;
        if (!raw[31] || raw == 32'h8000_0000) begin
            seed_start = 31'd1;
        end else begin
            seed_start = neg[VAL_W-1:0];
        end
    endfunction

endpackage

/* rtl/core/slcg_ram.sv */
module slcg_ram #(
    parameter int DATA_W = 31,
    parameter int DEPTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/slcg_lcg_step.sv */
module slcg_lcg_step
    import slcg_pkg::*;
(
    input  logic             i_clk,
    input  logic [VAL_W-1:0] i_operand,
    output logic [VAL_W-1:0] o_next
);

    logic [MUL_W-1:0] r_prod;
    logic [VAL_W:0]   sum;

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_W'(i_operand) * MUL_W'(LCG_MUL);
    end

    // 2^31 = 1 mod (2^31 - 1): one fold, one conditional subtract
    always_comb begin
        sum = {1'b0, r_prod[VAL_W-1:0]} + (VAL_W + 1)'(r_prod[MUL_W-1:VAL_W]);
        if (sum >= {1'b0, LCG_MOD}) begin
            o_next = VAL_W'(sum - {1'b0, LCG_MOD});
        end else begin
            o_next = sum[VAL_W-1:0];
        end
    end

endmodule

/* rtl/core/shuffled_lcg_random_generator_core.sv */
// Channel   Direction  Handshake               Payload
// request   in         i_valid / o_ready       i_restart
// result    out        o_valid / i_ready       o_random_value
// seed      in         i_seed_value_we         i_seed_value
//
// A plain draw does the multiply and the table read in S_DRAW_MUL, then the fold, the
// table write-back and loading the output register in S_DRAW_FOLD.
// A reseed first runs TABLE_DEPTH + 8 generator steps through the single multiply unit,
// each step going through S_SEED_MUL and S_SEED_FOLD, and then does a plain draw.
// Reset is synchronous; the first request after reset always reseeds.
// A held result stalls the draw in its last cycle until the output register frees.
module shuffled_lcg_random_generator_core
    import slcg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_restart,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [VAL_W-1:0] o_random_value,
    input  logic             i_seed_value_we,
    input  logic [31:0]      i_seed_value
);

    t_state r_state, n_state;
    logic [VAL_W-1:0] r_gen, n_gen;
    logic [VAL_W-1:0] r_last, n_last;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_random_value, n_random_value;
    logic [31:0]      r_seed_value;

    logic             out_free, draw_done, accept, need_seed;
    logic [VAL_W-1:0] last_now, quo, step_next;
    logic [IDX_W-1:0] idx;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr;
    logic [VAL_W-1:0] ram_wdata, ram_rdata;

    slcg_lcg_step u_step (
        .i_clk    (i_clk),
        .i_operand(r_gen),
        .o_next   (step_next)
    );

    slcg_ram #(
        .DATA_W(VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(idx),
        .o_rdata(ram_rdata)
    );

    assign quo = r_last / SHUF_DIV;
    assign idx = (quo >= VAL_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) : quo[IDX_W-1:0];

    assign out_free  = !r_out_valid || i_ready;
    assign draw_done = (r_state == S_DRAW_FOLD) && out_free;
    assign o_ready   = (r_state == S_IDLE) || draw_done;
    assign accept    = i_valid && o_ready;
    assign last_now  = draw_done ? ram_rdata : r_last;
    assign need_seed = i_restart || (last_now == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_gen        <= '0;
            r_last       <= '0;
            r_out_valid  <= 1'b0;
            r_seed_value <= '0;
        end else begin
            r_state     <= n_state;
            r_gen       <= n_gen;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_seed_value_we) begin
                r_seed_value <= i_seed_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt          <= n_cnt;
        r_random_value <= n_random_value;
    end

    always_comb begin
        n_state        = r_state;
        n_gen          = r_gen;
        n_last         = r_last;
        n_cnt          = r_cnt;
        n_random_value = r_random_value;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = idx;
        ram_wdata      = step_next;

        case (r_state)
            S_IDLE: begin
            end
            S_SEED_MUL: begin
                n_state = S_SEED_FOLD;
            end
            S_SEED_FOLD: begin
                n_gen = step_next;
                // table filled on the last TABLE_DEPTH steps, entry 0 last
                if (r_cnt < CNT_W'(TABLE_DEPTH)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cnt[IDX_W-1:0];
                end
                if (r_cnt == '0) begin
                    n_last  = step_next;
                    n_state = S_DRAW_MUL;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_state = S_SEED_MUL;
                end
            end
            S_DRAW_MUL: begin
                ram_re  = 1'b1;
                n_state = S_DRAW_FOLD;
            end
            S_DRAW_FOLD: begin
                if (draw_done) begin
                    n_gen          = step_next;
                    ram_we         = 1'b1;
                    n_last         = ram_rdata;
                    n_random_value = ram_rdata;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (accept) begin
            if (need_seed) begin
                n_gen   = seed_start(r_seed_value);
                n_cnt   = CNT_W'(SEED_STEPS - 1);
                n_state = S_SEED_MUL;
            end else begin
                n_state = S_DRAW_MUL;
            end
        end
    end

    always_comb begin
        if (draw_done) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_random_value = r_random_value;

    a_write_in_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SEED_FOLD || r_state == S_DRAW_FOLD))
        else $error("table written outside a fold cycle");

    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        draw_done |=> o_valid)
        else $error("finished draw did not load the output register");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SEED_MUL || r_state == S_DRAW_MUL))
        else $error("accepted request did not start work");

    a_seed_to_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEED_FOLD && r_cnt == '0) |=> r_state == S_DRAW_MUL)
        else $error("seeding did not hand over to the draw");

    a_no_read_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("table read and write in the same cycle");

endmodule
